/* sv/etl_pkg.sv */
// Shared types, character codes and helper functions of the expression token lexer.
package etl_pkg;

   // Longest number or name, in characters; a token is cut when it reaches this.
   localparam int MAX_TOKEN_CHARS = 15;
   localparam int LEN_W           = 4;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_CHARS);

   // Result queue between the front and back parts.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Token kinds as they appear on the result channel.
   localparam logic [2:0] TOK_NUMBER   = 3'd0;
   localparam logic [2:0] TOK_NAME     = 3'd1;
   localparam logic [2:0] TOK_OPEN     = 3'd2;
   localparam logic [2:0] TOK_CLOSE    = 3'd3;
   localparam logic [2:0] TOK_OPERATOR = 3'd4;

   // Character codes that the lexer looks for.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_OPEN    = 8'h28;
   localparam logic [7:0] CH_CLOSE   = 8'h29;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;

   // Kind of the token that is currently open in the front part.
   typedef enum logic [3:0] {
      OPEN_NONE = 4'b0001,
      OPEN_NUM  = 4'b0010,
      OPEN_NAME = 4'b0100,
      OPEN_DOT  = 4'b1000
   } open_kind_type;

   // One result word.
   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] token_char;
      logic       token_end;
      logic       expr_end;
   } result_type;

   // Zero, one or two result words pushed into the queue in one cycle.
   typedef struct packed {
      logic [1:0]            count;
      result_type [1:0]      slot;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic result_type pack_result(input logic [2:0] kind,
                                              input logic [7:0] ch,
                                              input logic       tend,
                                              input logic       eend);
      result_type r;
      r.token_kind = kind;
      r.token_char = ch;
      r.token_end  = tend;
      r.expr_end   = eend;
      return r;
   endfunction

endpackage

/* sv/etl_front.sv */
// Front part: accepts characters, tracks the open token and produces result words.
module etl_front
   import etl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_character,
   output logic       req_stall,
   input  logic       room,
   output push_type   push
);

   open_kind_type     kind_ff, kind_in;
   logic [7:0]        held_ff, held_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              stop_ff, stop_in;
   logic              accept;

   open_kind_type     kind_v;
   logic [LEN_W-1:0]  len_v;
   logic [LEN_W-1:0]  len_next;
   logic              more;
   logic              done;
   logic [2:0]        tk;
   logic [1:0]        n;
   result_type [1:0]  slot;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   always_comb begin
      kind_in  = kind_ff;
      held_in  = held_ff;
      len_in   = len_ff;
      stop_in  = stop_ff;
      kind_v   = kind_ff;
      len_v    = len_ff;
      len_next = '0;
      more     = 1'b0;
      done     = 1'b0;
      tk       = TOK_NUMBER;
      n        = 2'd0;
      slot     = '0;
      if (stop_ff) begin
         if (req_character == CH_NUL) begin
            stop_in = 1'b0;
         end
      end else begin
         // A held dot becomes a number only when a digit follows it.
         if (kind_v == OPEN_DOT) begin
            if (is_digit(req_character)) begin
               kind_v = OPEN_NUM;
               len_v  = LEN_W'(1);
               if (len_v >= MAX_LEN) begin
                  slot[n[0]] = pack_result(TOK_NUMBER, held_ff, 1'b1, 1'b0);
                  n          = n + 2'd1;
                  kind_v     = OPEN_NONE;
               end
            end else begin
               kind_v = OPEN_NONE;
            end
         end
         if (kind_v != OPEN_NONE) begin
            unique case (kind_v)
               OPEN_NUM: begin
                  more = is_digit(req_character) || (req_character == CH_DOT);
                  tk   = TOK_NUMBER;
               end
               OPEN_NAME: begin
                  more = is_letter(req_character) || is_digit(req_character);
                  tk   = TOK_NAME;
               end
               default: begin
                  more = 1'b0;
                  tk   = TOK_NUMBER;
               end
            endcase
            if (more) begin
               slot[n[0]] = pack_result(tk, held_ff, 1'b0, 1'b0);
               n          = n + 2'd1;
               len_next   = len_v + LEN_W'(1);
               if ((len_next >= MAX_LEN) || (len_next == '0)) begin
                  slot[n[0]] = pack_result(tk, req_character, 1'b1, 1'b0);
                  n          = n + 2'd1;
                  kind_in    = OPEN_NONE;
                  held_in    = '0;
                  len_in     = '0;
               end else begin
                  kind_in = kind_v;
                  held_in = req_character;
                  len_in  = len_next;
               end
               done = 1'b1;
            end else begin
               slot[n[0]] = pack_result(tk, held_ff, 1'b1, 1'b0);
               n          = n + 2'd1;
               kind_v     = OPEN_NONE;
            end
         end
         if (!done) begin
            kind_in = OPEN_NONE;
            held_in = '0;
            len_in  = '0;
            if ((req_character == CH_NUL) || (req_character == CH_EQUAL) ||
                (req_character == CH_NEWLINE)) begin
               slot[n[0]] = pack_result(TOK_NUMBER, CH_NUL, 1'b0, 1'b1);
               n          = n + 2'd1;
               if (req_character != CH_NUL) begin
                  stop_in = 1'b1;
               end
            end else if (is_digit(req_character) || is_letter(req_character)) begin
               tk = is_digit(req_character) ? TOK_NUMBER : TOK_NAME;
               if (MAX_TOKEN_CHARS <= 1) begin
                  slot[n[0]] = pack_result(tk, req_character, 1'b1, 1'b0);
                  n          = n + 2'd1;
               end else begin
                  kind_in = is_digit(req_character) ? OPEN_NUM : OPEN_NAME;
                  held_in = req_character;
                  len_in  = LEN_W'(1);
               end
            end else if (req_character == CH_DOT) begin
               kind_in = OPEN_DOT;
               held_in = req_character;
            end else begin
               case (req_character) inside
                  CH_OPEN: begin
                     slot[n[0]] = pack_result(TOK_OPEN, req_character, 1'b1, 1'b0);
                     n          = n + 2'd1;
                  end
                  CH_CLOSE: begin
                     slot[n[0]] = pack_result(TOK_CLOSE, req_character, 1'b1, 1'b0);
                     n          = n + 2'd1;
                  end
                  CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                     slot[n[0]] = pack_result(TOK_OPERATOR, req_character, 1'b1, 1'b0);
                     n          = n + 2'd1;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      push.count = accept ? n : 2'd0;
      push.slot  = slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= OPEN_NONE;
         held_ff <= '0;
         len_ff  <= '0;
         stop_ff <= 1'b0;
      end else if (accept) begin
         kind_ff <= kind_in;
         held_ff <= held_in;
         len_ff  <= len_in;
         stop_ff <= stop_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An expression only stops after its open token has been closed.
   a_stop_closed: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> (kind_ff == OPEN_NONE))
      else $error("stopped with a token still open");

   // A pending dot holds the dot itself and counts no characters yet.
   a_dot_held: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == OPEN_DOT) |-> ((held_ff == CH_DOT) && (len_ff == '0)))
      else $error("pending dot state is inconsistent");

   // An open number or name never reaches the cut length while still held.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      ((kind_ff == OPEN_NUM) || (kind_ff == OPEN_NAME)) |->
         ((len_ff != '0) && (len_ff < MAX_LEN)))
      else $error("open token length out of range");
`endif

endmodule

/* sv/etl_queue.sv */
// Result queue: takes up to two words per cycle from the front and hands one to the back.
module etl_queue
   import etl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   input  logic       pop,
   output result_type head,
   output logic       head_valid
);

   result_type             entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;

   // Room means a full pair of words can still be taken.
   assign room       = (count_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop);
      count_in  = count_ff + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.slot[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + Q_PTR_W'(1)] <= push.slot[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("push without room");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

/* sv/etl_back.sv */
// Back part: output register that delivers one result word per cycle while rsp_stall is low.
module etl_back
   import etl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type head,
   input  logic       head_valid,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_end,
   output logic       rsp_expr_end
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign pop      = head_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_token_kind = data_ff.token_kind;
   assign rsp_token_char = data_ff.token_char;
   assign rsp_token_end  = data_ff.token_end;
   assign rsp_expr_end   = data_ff.expr_end;

endmodule

/* sv/expression_token_lexer_core.sv */
// Top level of the expression token lexer: front, result queue and output stage.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_character (8 bits)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_token_kind, rsp_token_char,
//           |           |                        | rsp_token_end, rsp_expr_end
//
// A character word is taken every clock while the result queue can hold two
// more words; the front decides all results of a character in that cycle.
// Results leave at one word per clock through the output register while rsp
// is not stalled, so the output port sets the sustained rate: a character
// that yields two words outruns it, and the four-entry queue absorbs such bursts.
// A result word passes through a queue entry and then the output register.
// Reset is synchronous; no clearing pass follows it.
// A stall on rsp backs up into the queue and only then raises req_stall.
module expression_token_lexer_core
   import etl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_character,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_end,
   output logic       rsp_expr_end
);

   // Words produced by the front for the character accepted this cycle.
   push_type   push;
   // The queue can take a full pair of words.
   logic       room;
   // Oldest queued word and the back part's request for it.
   result_type head;
   logic       head_valid;
   logic       pop;

   // The front holds one character back because it learns that a character
   // is the last of its token only when the next one arrives.
   etl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_stall     (req_stall),
      .room          (room),
      .push          (push)
   );

   etl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   etl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_char (rsp_token_char),
      .rsp_token_end  (rsp_token_end),
      .rsp_expr_end   (rsp_expr_end)
   );

endmodule

/* bench/tb_expression_token_lexer_core.sv */
// Testbench for the expression token lexer: directed and random text, checks every result word.
`timescale 1ns / 100ps

module tb_expression_token_lexer_core;
   import etl_pkg::*;

   // Character codes used by the stimulus, beside the ones the package names.
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // Stimulus phases; each one sets how often the two sides idle.
   typedef enum int {
      PH_DIRECTED,
      PH_PRESSURE,
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE
   } phase_type;

   localparam int HOLD_CYCLES = 120;
   localparam int DRAIN_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_character = 8'h00;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_token_kind;
   logic [7:0] rsp_token_char;
   logic       rsp_token_end;
   logic       rsp_expr_end;

   expression_token_lexer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_character  (req_character),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_char (rsp_token_char),
      .rsp_token_end  (rsp_token_end),
      .rsp_expr_end   (rsp_expr_end)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Characters waiting to be offered, and result words the lexer still owes.
   logic [7:0]  text_q[$];
   result_type  token_words[$];

   phase_type   phase = PH_DIRECTED;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned planned = 0;

   int unsigned chars_taken = 0;
   int unsigned words_checked = 0;
   int unsigned expr_count = 0;
   int unsigned cut_count = 0;
   int unsigned errors = 0;

   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   // ------------------------------------------------------------------
   // Lexer state as the testbench sees it. A number or name character is
   // kept back until the next byte shows whether it is the token's last.
   // ------------------------------------------------------------------
   logic [7:0]       pend_char = 8'h00;
   open_kind_type    open_tok = OPEN_NONE;
   logic [LEN_W-1:0] tok_len = '0;
   logic             halted = 1'b0;

   function automatic logic digit_char(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25);
   endfunction

   task automatic owe_word(input logic [2:0] kind, input logic [7:0] ch,
                           input logic tend, input logic eend);
      result_type w;
      w.token_kind = kind;
      w.token_char = ch;
      w.token_end  = tend;
      w.expr_end   = eend;
      token_words.push_back(w);
   endtask

   task automatic drop_token();
      open_tok  = OPEN_NONE;
      pend_char = 8'h00;
      tok_len   = '0;
   endtask

   // A number or name starts at c. With a one-character limit it is done at once.
   task automatic start_word(input open_kind_type kind, input logic [7:0] c);
      if (MAX_TOKEN_CHARS <= 1) begin
         owe_word(kind == OPEN_NUM ? TOK_NUMBER : TOK_NAME, c, 1'b1, 1'b0);
         cut_count++;
         drop_token();
      end else begin
         open_tok  = kind;
         pend_char = c;
         tok_len   = LEN_W'(1);
      end
   endtask

   // Works out the result words that one accepted character causes.
   task automatic lex_char(input logic [7:0] c);
      logic       more;
      logic [2:0] kind;
      if (halted) begin
         // After '=' or newline only a NUL matters, and it emits nothing.
         if (c == CH_NUL)
            halted = 1'b0;
         return;
      end
      // A held dot becomes a number only when a digit follows it.
      if (open_tok == OPEN_DOT) begin
         if (digit_char(c)) begin
            open_tok = OPEN_NUM;
            tok_len  = LEN_W'(1);
            if (tok_len >= MAX_LEN) begin
               owe_word(TOK_NUMBER, pend_char, 1'b1, 1'b0);
               cut_count++;
               drop_token();
            end
         end else begin
            drop_token();
         end
      end
      if (open_tok != OPEN_NONE) begin
         more = (open_tok == OPEN_NUM) ? (digit_char(c) || c == CH_DOT)
                                       : (letter_char(c) || digit_char(c));
         kind = (open_tok == OPEN_NUM) ? TOK_NUMBER : TOK_NAME;
         if (more) begin
            owe_word(kind, pend_char, 1'b0, 1'b0);
            tok_len = tok_len + LEN_W'(1);
            if (tok_len >= MAX_LEN || tok_len == '0) begin
               // The character that reaches the limit goes out at once.
               owe_word(kind, c, 1'b1, 1'b0);
               cut_count++;
               drop_token();
            end else begin
               pend_char = c;
            end
            return;
         end
         owe_word(kind, pend_char, 1'b1, 1'b0);
         drop_token();
      end
      if (c == CH_NUL || c == CH_EQUAL || c == CH_NEWLINE) begin
         owe_word(TOK_NUMBER, CH_NUL, 1'b0, 1'b1);
         expr_count++;
         if (c != CH_NUL)
            halted = 1'b1;
      end else if (digit_char(c)) begin
         start_word(OPEN_NUM, c);
      end else if (letter_char(c)) begin
         start_word(OPEN_NAME, c);
      end else if (c == CH_DOT) begin
         open_tok  = OPEN_DOT;
         pend_char = c;
         tok_len   = '0;
      end else if (c == CH_OPEN) begin
         owe_word(TOK_OPEN, c, 1'b1, 1'b0);
      end else if (c == CH_CLOSE) begin
         owe_word(TOK_CLOSE, c, 1'b1, 1'b0);
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
         owe_word(TOK_OPERATOR, c, 1'b1, 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: offers the next queued character, holds it steady while the
   // lexer stalls, and hands every accepted character to the predictor.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            lex_char(req_character);
            chars_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (text_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
               req_valid     <= 1'b1;
               req_character <= text_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off of the result side, once, in the pressure phase. The
   // sender keeps offering meanwhile, so the result queue fills and the
   // lexer has to stall its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (phase == PH_PRESSURE && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every accepted result word is compared with the oldest word
   // still owed; it also drives the random stall of the result side.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (token_words.size() == 0) begin
               $error("unexpected result word: kind %0d char %02h end %0b expr %0b",
                      rsp_token_kind, rsp_token_char, rsp_token_end, rsp_expr_end);
               errors++;
            end else begin
               want = token_words.pop_front();
               words_checked++;
               if (rsp_token_kind !== want.token_kind) begin
                  $error("token_kind: expected %0d, got %0d", want.token_kind, rsp_token_kind);
                  errors++;
               end
               if (rsp_token_char !== want.token_char) begin
                  $error("token_char: expected %02h, got %02h", want.token_char, rsp_token_char);
                  errors++;
               end
               if (rsp_token_end !== want.token_end) begin
                  $error("token_end: expected %0b, got %0b", want.token_end, rsp_token_end);
                  errors++;
               end
               if (rsp_expr_end !== want.expr_end) begin
                  $error("expr_end: expected %0b, got %0b", want.expr_end, rsp_expr_end);
                  errors++;
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(1, 100) <= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus generation.
   // ------------------------------------------------------------------
   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'($urandom_range(0, 25));
   endfunction

   task automatic queue_char(input logic [7:0] c);
      text_q.push_back(c);
      planned++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_char(s[i]);
   endtask

   // Mostly well-formed expressions with random content: numbers (some
   // starting with a dot, some past the length limit), names, parens,
   // operators and white space, ended by NUL, '=' or newline. One in ten
   // is plain noise.
   task automatic add_expression();
      int unsigned n_tok;
      int unsigned len;
      int unsigned pick;
      if ($urandom_range(0, 9) == 0) begin
         n_tok = $urandom_range(1, 12);
         repeat (n_tok) queue_char(8'($urandom_range(0, 255)));
         queue_char(CH_NUL);
         return;
      end
      n_tok = $urandom_range(1, 8);
      repeat (n_tok) begin
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 5);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            if ($urandom_range(0, 5) == 0)
               queue_char(CH_DOT);
            queue_char(rand_digit());
            repeat (len - 1) queue_char($urandom_range(0, 6) == 0 ? CH_DOT : rand_digit());
         end else if (pick < 55) begin
            queue_char(rand_letter());
            repeat (len - 1) queue_char($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
         end else if (pick < 65) begin
            queue_char($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0: queue_char(CH_PLUS);
               1: queue_char(CH_MINUS);
               2: queue_char(CH_STAR);
               default: queue_char(CH_SLASH);
            endcase
         end else if (pick < 95) begin
            queue_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         end else begin
            queue_char(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 2) == 0)
            queue_char(CH_SPACE);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         queue_char(CH_NUL);
      end else begin
         queue_char(pick < 85 ? CH_EQUAL : CH_NEWLINE);
         // Bytes after the end are ignored and do not count as work.
         repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
         text_q.push_back(CH_NUL);
      end
   endtask

   task automatic run_phase(input phase_type ph, input int unsigned send_pct,
                            input int unsigned recv_pct, input int unsigned count);
      int unsigned goal;
      @(negedge clock);
      phase          = ph;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      goal = planned + count;
      while (planned < goal)
         add_expression();
      while (text_q.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed text: a dot-led number, a name with a digit, both parens,
      // every operator, a lone dot, white space, an '=' followed by an
      // ignored byte, unknown bytes at both ends of the range, a newline
      // that closes an open name, and a NUL right after another NUL.
      @(negedge clock);
      queue_text("(.5+a9)-.x*8 /\t=q");
      queue_char(CH_NUL);
      queue_char(8'hFF);
      queue_char(8'h01);
      queue_text("Z\nk");
      queue_char(CH_NUL);
      queue_char(CH_NUL);
      while (text_q.size() != 0 || req_valid)
         @(negedge clock);

      run_phase(PH_PRESSURE,   0,  0,  250);
      run_phase(PH_FREE,       0,  0,  250);
      run_phase(PH_SEND_IDLE,  71, 0,  300);
      run_phase(PH_RECV_STALL, 0,  71, 300);
      run_phase(PH_BOTH_IDLE,  26, 26, 400);

      // Let the owed words come out, then wait out the drain period before the final check.
      while (token_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (token_words.size() != 0) begin
         $error("%0d result words never arrived", token_words.size());
         errors++;
      end

      $display("Lexed %0d characters into %0d result words over %0d expressions;",
               chars_taken, words_checked, expr_count);
      $display("%0d tokens were cut at the length limit, %0d mismatches found.",
               cut_count, errors);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
